@@ hw/rtl/mra_pkg.sv @@
// Shared types, constants and helper functions for the module region allocator.
// Used by the controller, the datapath, the top level and the checker.
// Has no dependencies.
package mra_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int ID_W    = 32;
    localparam int STAT_W  = 3;
    localparam int SLOT_OUT_W = 3;
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int PAGE_W  = $clog2(PAGE_BYTES);
    localparam int SPAN_W  = SIZE_W + 2;
    localparam int SUM_W   = ADDR_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LIMIT = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_CODE_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_STACK_FULL = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_BOTH_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_TABLE_FULL = 3'd4;

    localparam logic [ADDR_W-1:0] ALLOC_BASE_RESET  = 48'h0000_4000_0000;
    localparam logic [ADDR_W-1:0] ALLOC_LIMIT_RESET = 48'h0000_8000_0000;

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   new_module_id;
        logic [SIZE_W-1:0] new_code_size;
        logic [SIZE_W-1:0] new_stack_size;
        logic [ADDR_W-1:0] probe_address;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       found_module_id;
        logic [ADDR_W-1:0]     code_start;
        logic [SIZE_W-1:0]     code_length;
        logic [ADDR_W-1:0]     stack_start;
        logic [SIZE_W-1:0]     stack_length;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic code_step;
        logic stack_step;
        logic mark_full;
        logic read;
        logic scan_next;
        logic mark_hit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic full;
        logic scan_end;
        logic match;
    } dp_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_STACK,
        S_READ,
        S_CHECK,
        S_DONE
    } ctl_state_t;

    function automatic logic [SPAN_W-1:0] page_round(input logic [SPAN_W-1:0] bytes);
        logic [SPAN_W-1:0] sum;
        sum = bytes + SPAN_W'(PAGE_BYTES - 1);
        return {sum[SPAN_W-1:PAGE_W], PAGE_W'(0)};
    endfunction

endpackage

@@ hw/rtl/module_region_allocator.sv @@
// A load runs the code and then the stack bump step before its result is registered, and the
// next transaction is accepted once the result register is loaded; a full table skips both steps.
// A lookup scans the used slots in order until a hit or the end, then registers its result;
// each scanned slot costs one registered table read and one range compare.
// One transaction is in flight at a time; a stalled result delays the next acceptance.
// Reset (rst_n low, asynchronous) reloads the bump pointer, empties the table and both registers.
module module_region_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [mra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mra_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mra_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mra_pkg::out_item_t            out_data
);
    import mra_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mra_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mra_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (in_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_data     (out_data)
    );

endmodule

@@ hw/rtl/mra_controller.sv @@
// Controller state machine of the module region allocator.
// Sequences loads and lookups and owns the result valid flag.
// Depends on mra_pkg.
module mra_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  mra_pkg::dp_sts_t sts,
    output mra_pkg::dp_cmd_t cmd
);
    import mra_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CODE;
                end
            end
            S_CODE:
            begin
                if (sts.is_lookup)
                begin
                    state_next = S_READ;
                end
                else if (sts.full)
                begin
                    cmd.mark_full = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.code_step = 1'b1;
                    state_next    = S_STACK;
                end
            end
            S_STACK:
            begin
                cmd.stack_step = 1'b1;
                state_next     = S_DONE;
            end
            S_READ:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.match)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mra_datapath.sv @@
// Datapath of the module region allocator: bump pointer, region table,
// range compare and result register.
// Depends on mra_pkg.
module mra_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [mra_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mra_pkg::ADDR_W-1:0]          cfg_data,
    input  mra_pkg::in_item_t                   in_data,
    input  mra_pkg::dp_cmd_t                    cmd,
    output mra_pkg::dp_sts_t                    sts,
    output mra_pkg::out_item_t                  out_data
);
    import mra_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [ADDR_W-1:0] cbase;
        logic [SIZE_W-1:0] clen;
        logic [ADDR_W-1:0] sbase;
        logic [SIZE_W-1:0] slen;
    } entry_t;

    entry_t            table_mem [SLOT_COUNT];
    entry_t            rd_reg;

    logic [ADDR_W-1:0] alloc_limit_reg;
    logic [ADDR_W-1:0] next_free_reg;
    logic [CNT_W-1:0]  used_reg;

    in_item_t          item_reg;
    logic [SPAN_W-1:0] code_span_reg;
    logic [SPAN_W-1:0] stack_span_reg;
    logic [ADDR_W-1:0] cbase_reg;
    logic [ADDR_W-1:0] sbase_reg;
    logic              code_ok_reg;
    logic              stack_ok_reg;
    logic              full_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  scan_reg;
    out_item_t         out_reg;

    logic [SPAN_W-1:0] step_span;
    logic [SUM_W-1:0]  bump_sum;
    logic              bump_fits;
    logic [SUM_W-1:0]  region_end;
    logic              commit;
    entry_t            new_entry;
    out_item_t         res;

    assign step_span  = cmd.code_step ? code_span_reg : stack_span_reg;
    assign bump_sum   = {1'b0, next_free_reg} + SUM_W'(step_span);
    assign bump_fits  = (bump_sum <= {1'b0, alloc_limit_reg});
    assign region_end = {1'b0, rd_reg.cbase} + SUM_W'(rd_reg.clen);

    assign sts.is_lookup = (item_reg.action == ACTION_LOOKUP);
    assign sts.full      = (used_reg >= CNT_W'(SLOT_COUNT));
    assign sts.scan_end  = (scan_reg >= used_reg);
    assign sts.match     = (item_reg.probe_address >= rd_reg.cbase)
                        && ({1'b0, item_reg.probe_address} < region_end);

    assign commit = cmd.finish && (item_reg.action == ACTION_LOAD) && !full_reg
                 && code_ok_reg && stack_ok_reg;

    assign new_entry.owner = item_reg.new_module_id;
    assign new_entry.cbase = cbase_reg;
    assign new_entry.clen  = item_reg.new_code_size;
    assign new_entry.sbase = sbase_reg;
    assign new_entry.slen  = item_reg.new_stack_size;

    always_comb
    begin
        res = '0;
        if (item_reg.action == ACTION_LOOKUP)
        begin
            if (hit_reg)
            begin
                res.status          = STATUS_OK;
                res.hit             = 1'b1;
                res.slot            = SLOT_OUT_W'(scan_reg);
                res.found_module_id = rd_reg.owner;
                res.code_start      = rd_reg.cbase;
                res.code_length     = rd_reg.clen;
                res.stack_start     = rd_reg.sbase;
                res.stack_length    = rd_reg.slen;
            end
        end
        else if (full_reg)
        begin
            res.status = STATUS_TABLE_FULL;
        end
        else if (!code_ok_reg && !stack_ok_reg)
        begin
            res.status = STATUS_BOTH_FULL;
        end
        else if (!code_ok_reg)
        begin
            res.status = STATUS_CODE_FULL;
        end
        else if (!stack_ok_reg)
        begin
            res.status = STATUS_STACK_FULL;
        end
        else
        begin
            res.status          = STATUS_OK;
            res.slot            = SLOT_OUT_W'(used_reg);
            res.found_module_id = new_entry.owner;
            res.code_start      = new_entry.cbase;
            res.code_length     = new_entry.clen;
            res.stack_start     = new_entry.sbase;
            res.stack_length    = new_entry.slen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_limit_reg <= ALLOC_LIMIT_RESET;
            next_free_reg   <= ALLOC_BASE_RESET;
            used_reg        <= '0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == CFG_ALLOC_BASE))
            begin
                next_free_reg <= cfg_data;
            end
            else if ((cmd.code_step || cmd.stack_step) && bump_fits)
            begin
                next_free_reg <= bump_sum[ADDR_W-1:0];
            end
            if (cfg_write_en && (cfg_index == CFG_ALLOC_LIMIT))
            begin
                alloc_limit_reg <= cfg_data;
            end
            if (commit)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_reg       <= in_data;
            code_span_reg  <= page_round(SPAN_W'(in_data.new_code_size));
            stack_span_reg <= page_round(SPAN_W'(in_data.new_stack_size)
                                         + SPAN_W'(PAGE_BYTES));
            code_ok_reg    <= 1'b0;
            stack_ok_reg   <= 1'b0;
            full_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            scan_reg       <= '0;
        end
        if (cmd.mark_full)
        begin
            full_reg <= 1'b1;
        end
        if (cmd.code_step)
        begin
            code_ok_reg <= bump_fits;
            cbase_reg   <= next_free_reg;
        end
        if (cmd.stack_step)
        begin
            stack_ok_reg <= bump_fits;
            sbase_reg    <= next_free_reg + ADDR_W'(PAGE_BYTES);
        end
        if (cmd.mark_hit)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + CNT_W'(1);
        end
        if (cmd.read)
        begin
            rd_reg <= table_mem[scan_reg[SLOT_W-1:0]];
        end
        if (commit)
        begin
            table_mem[used_reg[SLOT_W-1:0]] <= new_entry;
        end
        if (cmd.finish)
        begin
            out_reg <= res;
        end
    end

    assign out_data = out_reg;

endmodule

@@ hw/rtl/mra_checker.sv @@
// Port-level checker for the module region allocator and its bind statement.
// Depends on mra_pkg and the top level module_region_allocator.
module mra_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input mra_pkg::out_item_t            out_data
);
    import mra_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("Result payload changed while stalled.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("A second transaction was accepted before the first finished.");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.status == STATUS_OK)
        else $error("Lookup hit reported with an error status.");

    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STATUS_OK)
        |-> !out_data.hit && (out_data.slot == '0) && (out_data.code_start == '0)
            && (out_data.stack_start == '0))
        else $error("Failed load reported entry fields.");

endmodule

bind module_region_allocator mra_checker u_mra_checker (.*);
